[src/dsc_pkg.sv]
// Package for the delta sample channel: action codes, register map,
// constants and the result word type. No dependencies.

package dsc_pkg;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_DELIVER = 2'd2;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_RATE_PERIOD   = 3'd0;
  localparam logic [2:0] REG_START_ADDRESS = 3'd1;
  localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd2;
  localparam logic [2:0] REG_LOOP_ENABLE   = 3'd3;
  localparam logic [2:0] REG_IRQ_ENABLE    = 3'd4;

  localparam logic [9:0]  RATE_PERIOD_RST   = 10'd428;
  localparam logic [15:0] START_ADDRESS_RST = 16'hC000;
  localparam logic [11:0] SAMPLE_LENGTH_RST = 12'd1;

  localparam logic [6:0]  LEVEL_TOP     = 7'd126;
  localparam logic [15:0] WRAP_ADDR     = 16'h8000;
  localparam logic [15:0] LAST_ADDR     = 16'hFFFF;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [6:0]  output_level;
    logic        fetch_request;
    logic [15:0] fetch_address;
    logic        irq_flag;
    logic        playing;
  } dsc_result_t;

endpackage

[src/dsc_if.sv]
// Valid/ready channel interfaces for the delta sample channel's input and
// result words.

interface dsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] fetched_byte;

  modport source (output valid, output action, output fetched_byte, input ready);
  modport sink (input valid, input action, input fetched_byte, output ready);
endinterface

interface dsc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  output_level;
  logic        fetch_request;
  logic [15:0] fetch_address;
  logic        irq_flag;
  logic        playing;

  modport source (output valid, output output_level, output fetch_request,
                  output fetch_address, output irq_flag, output playing, input ready);
  modport sink (input valid, input output_level, input fetch_request,
                input fetch_address, input irq_flag, input playing, output ready);
endinterface

[src/delta_sample_channel.sv]
// Delta-modulation sample channel with APB register port and valid/ready
// input and result channels. Depends on dsc_pkg and the interfaces in dsc_if.
//
//   channel   direction  word                                 accepted when
//   in_ch     in         action, fetched_byte                 valid && ready
//   out_ch    out        level, request, address, irq, playing valid && ready
//   APB       in/out     rate, start, length, loop, irq_en    psel && penable && pwrite
//
// Each input word updates the channel state; its result word is registered in the output
// register, so one word per cycle is sustained while the consumer does not stall.
// A skid register behind the output register keeps one more input word accepted
// while the consumer stalls; in_ch.ready drops only when the skid register is full.
// Reset is synchronous and active low; it restores all registers but main_r and skid_r.

module delta_sample_channel (
  input  logic                         clk,
  input  logic                         rst_n,
  dsc_in_if.sink                       in_ch,
  dsc_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dsc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import dsc_pkg::*;

  logic [9:0]  rate_period_r;
  logic [15:0] start_address_r;
  logic [11:0] sample_length_r;
  logic        loop_enable_r;
  logic        irq_enable_r;

  logic [9:0]  period_count_r, period_count_nxt;
  logic [6:0]  delta_level_r, delta_level_nxt;
  logic [7:0]  bit_shifter_r, bit_shifter_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [7:0]  sample_buffer_r, sample_buffer_nxt;
  logic        buffer_empty_r, buffer_empty_nxt;
  logic        silent_r, silent_nxt;
  logic [15:0] current_address_r, current_address_nxt;
  logic [11:0] bytes_remaining_r, bytes_remaining_nxt;
  logic        irq_pending_r, irq_pending_nxt;
  logic        fetch_outstanding_r, fetch_outstanding_nxt;

  dsc_result_t result;
  dsc_result_t main_r, skid_r;
  logic        main_valid_r, skid_valid_r;
  logic        push, pop, cfg_write;
  logic [3:0]  bits_dec;
  logic [11:0] remaining_dec;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_period_r   <= RATE_PERIOD_RST;
      start_address_r <= START_ADDRESS_RST;
      sample_length_r <= SAMPLE_LENGTH_RST;
      loop_enable_r   <= 1'b0;
      irq_enable_r    <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_RATE_PERIOD:   rate_period_r   <= pwdata[9:0];
        REG_START_ADDRESS: start_address_r <= pwdata[15:0];
        REG_SAMPLE_LENGTH: sample_length_r <= pwdata[11:0];
        REG_LOOP_ENABLE:   loop_enable_r   <= pwdata[0];
        REG_IRQ_ENABLE:    irq_enable_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RATE_PERIOD:   prdata = {22'd0, rate_period_r};
      REG_START_ADDRESS: prdata = {16'd0, start_address_r};
      REG_SAMPLE_LENGTH: prdata = {20'd0, sample_length_r};
      REG_LOOP_ENABLE:   prdata = {31'd0, loop_enable_r};
      REG_IRQ_ENABLE:    prdata = {31'd0, irq_enable_r};
      default:           prdata = '0;
    endcase
  end

  // Channel state update for one input word
  assign bits_dec      = bits_left_r - 4'd1;
  assign remaining_dec = bytes_remaining_r - 12'd1;

  always_comb begin
    period_count_nxt      = period_count_r;
    delta_level_nxt       = delta_level_r;
    bit_shifter_nxt       = bit_shifter_r;
    bits_left_nxt         = bits_left_r;
    sample_buffer_nxt     = sample_buffer_r;
    buffer_empty_nxt      = buffer_empty_r;
    silent_nxt            = silent_r;
    current_address_nxt   = current_address_r;
    bytes_remaining_nxt   = bytes_remaining_r;
    irq_pending_nxt       = irq_pending_r;
    fetch_outstanding_nxt = fetch_outstanding_r;

    case (in_ch.action)
      ACT_TICK: begin
        if (period_count_r > 10'd1) begin
          period_count_nxt = period_count_r - 10'd1;
        end else begin
          period_count_nxt = rate_period_r;
          if (!silent_r) begin
            if (!bit_shifter_r[0]) begin
              if (delta_level_r > 7'd1) delta_level_nxt = delta_level_r - 7'd2;
            end else begin
              if (delta_level_r < LEVEL_TOP) delta_level_nxt = delta_level_r + 7'd2;
            end
          end
          bit_shifter_nxt = {1'b0, bit_shifter_r[7:1]};
          bits_left_nxt   = bits_dec;
          if (bits_dec == 4'd0) begin
            bits_left_nxt = BITS_PER_BYTE;
            if (!buffer_empty_r) begin
              bit_shifter_nxt  = sample_buffer_r;
              buffer_empty_nxt = 1'b1;
              silent_nxt       = 1'b0;
            end else begin
              silent_nxt = 1'b1;
            end
          end
        end
      end
      ACT_START: begin
        irq_pending_nxt = 1'b0;
        if (bytes_remaining_r == 12'd0) begin
          current_address_nxt = start_address_r;
          bytes_remaining_nxt = sample_length_r;
        end
      end
      ACT_DELIVER: begin
        if (fetch_outstanding_r) begin
          fetch_outstanding_nxt = 1'b0;
          sample_buffer_nxt     = in_ch.fetched_byte;
          buffer_empty_nxt      = 1'b0;
          current_address_nxt   = (current_address_r == LAST_ADDR) ? WRAP_ADDR
                                                                   : current_address_r + 16'd1;
          bytes_remaining_nxt   = remaining_dec;
          if (remaining_dec == 12'd0) begin
            if (loop_enable_r) begin
              bytes_remaining_nxt = sample_length_r;
              current_address_nxt = start_address_r;
            end else if (irq_enable_r) begin
              irq_pending_nxt = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (buffer_empty_nxt && bytes_remaining_nxt != 12'd0) fetch_outstanding_nxt = 1'b1;

    result.output_level  = delta_level_nxt;
    result.fetch_request = fetch_outstanding_nxt;
    result.fetch_address = fetch_outstanding_nxt ? current_address_nxt : 16'd0;
    result.irq_flag      = irq_pending_nxt;
    result.playing       = bytes_remaining_nxt != 12'd0;
  end

  // Handshake
  assign in_ch.ready = !skid_valid_r;
  assign push        = in_ch.valid && !skid_valid_r;
  assign pop         = main_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r      <= 10'd1;
      delta_level_r       <= 7'd0;
      bit_shifter_r       <= 8'd0;
      bits_left_r         <= BITS_PER_BYTE;
      sample_buffer_r     <= 8'd0;
      buffer_empty_r      <= 1'b1;
      silent_r            <= 1'b1;
      current_address_r   <= 16'd0;
      bytes_remaining_r   <= 12'd0;
      irq_pending_r       <= 1'b0;
      fetch_outstanding_r <= 1'b0;
    end else if (push) begin
      period_count_r      <= period_count_nxt;
      delta_level_r       <= delta_level_nxt;
      bit_shifter_r       <= bit_shifter_nxt;
      bits_left_r         <= bits_left_nxt;
      sample_buffer_r     <= sample_buffer_nxt;
      buffer_empty_r      <= buffer_empty_nxt;
      silent_r            <= silent_nxt;
      current_address_r   <= current_address_nxt;
      bytes_remaining_r   <= bytes_remaining_nxt;
      irq_pending_r       <= irq_pending_nxt;
      fetch_outstanding_r <= fetch_outstanding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  assign out_ch.valid         = main_valid_r;
  assign out_ch.output_level  = main_r.output_level;
  assign out_ch.fetch_request = main_r.fetch_request;
  assign out_ch.fetch_address = main_r.fetch_address;
  assign out_ch.irq_flag      = main_r.irq_flag;
  assign out_ch.playing       = main_r.playing;

  // Checks
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r) else $error("skid word held without output word");

  a_fetch_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_outstanding_r |-> (bytes_remaining_r != 12'd0 && buffer_empty_r))
    else $error("fetch outstanding with full buffer or no bytes left");

  a_level_even: assert property (@(posedge clk) disable iff (!rst_n)
    !delta_level_r[0] && delta_level_r <= LEVEL_TOP) else $error("delta level out of range");

  a_no_address_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && !main_r.fetch_request) |-> main_r.fetch_address == 16'd0)
    else $error("fetch address set without request");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (main_valid_r && !skid_valid_r))
    else $error("skid word lost on drain");

endmodule

[tb/sv/dsc_result_checker.sv]
// Result checker for the delta sample channel: follows register writes and input
// words, predicts every result word and compares it with what the channel sends.
// Depends on dsc_pkg and the channel interfaces in dsc_if.

module dsc_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  dsc_in_if                           in_ch,
  dsc_out_if                          out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [dsc_pkg::PADDR_W-1:0] paddr,
  input  logic [dsc_pkg::PDATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          pending,
  output logic                        fetch_wanted
);
  import dsc_pkg::*;

  logic [9:0]  rate_q;
  logic [15:0] start_q;
  logic [11:0] length_q;
  logic        loop_q;
  logic        irq_en_q;

  logic [9:0]  countdown;
  logic [6:0]  level;
  logic [7:0]  shifter;
  logic [3:0]  bits_left;
  logic [7:0]  buffer;
  logic        buffer_empty;
  logic        silent;
  logic [15:0] address;
  logic [11:0] remaining;
  logic        irq_pending;
  logic        outstanding;

  dsc_result_t expected_words[$];
  dsc_result_t exp_word;
  dsc_result_t next_word;
  int          failures = 0;

  task automatic reset_channel();
    rate_q       = RATE_PERIOD_RST;
    start_q      = START_ADDRESS_RST;
    length_q     = SAMPLE_LENGTH_RST;
    loop_q       = 1'b0;
    irq_en_q     = 1'b0;
    countdown    = 10'd1;
    level        = 7'd0;
    shifter      = 8'd0;
    bits_left    = BITS_PER_BYTE;
    buffer       = 8'd0;
    buffer_empty = 1'b1;
    silent       = 1'b1;
    address      = 16'd0;
    remaining    = 12'd0;
    irq_pending  = 1'b0;
    outstanding  = 1'b0;
  endtask

  task automatic step_channel(input logic [1:0] action, input logic [7:0] data,
                              output dsc_result_t word);
    case (action)
      ACT_TICK: begin
        if (countdown > 10'd1) begin
          countdown = countdown - 10'd1;
        end else begin
          countdown = rate_q;
          if (!silent) begin
            if (!shifter[0]) begin
              if (level > 7'd1) level = level - 7'd2;
            end else if (level < LEVEL_TOP) begin
              level = level + 7'd2;
            end
          end
          shifter   = shifter >> 1;
          bits_left = bits_left - 4'd1;
          if (bits_left == 4'd0) begin
            bits_left = BITS_PER_BYTE;
            if (!buffer_empty) begin
              shifter      = buffer;
              buffer_empty = 1'b1;
              silent       = 1'b0;
            end else begin
              silent = 1'b1;
            end
          end
        end
      end
      ACT_START: begin
        irq_pending = 1'b0;
        if (remaining == 12'd0) begin
          address   = start_q;
          remaining = length_q;
        end
      end
      ACT_DELIVER: begin
        if (outstanding) begin
          outstanding  = 1'b0;
          buffer       = data;
          buffer_empty = 1'b0;
          address      = (address == LAST_ADDR) ? WRAP_ADDR : address + 16'd1;
          remaining    = remaining - 12'd1;
          if (remaining == 12'd0) begin
            if (loop_q) begin
              remaining = length_q;
              address   = start_q;
            end else if (irq_en_q) begin
              irq_pending = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (buffer_empty && remaining != 12'd0 && !outstanding) outstanding = 1'b1;

    word.output_level  = level;
    word.fetch_request = outstanding;
    word.fetch_address = outstanding ? address : 16'd0;
    word.irq_flag      = irq_pending;
    word.playing       = (remaining != 12'd0);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_channel();
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_RATE_PERIOD:   rate_q   = pwdata[9:0];
          REG_START_ADDRESS: start_q  = pwdata[15:0];
          REG_SAMPLE_LENGTH: length_q = pwdata[11:0];
          REG_LOOP_ENABLE:   loop_q   = pwdata[0];
          REG_IRQ_ENABLE:    irq_en_q = pwdata[0];
          default: begin
          end
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with none expected, got level %0d address %0h",
                   $time, out_ch.output_level, out_ch.fetch_address);
          failures++;
        end else begin
          exp_word = expected_words.pop_front();
          check_field("output_level", exp_word.output_level, out_ch.output_level);
          check_field("fetch_request", exp_word.fetch_request, out_ch.fetch_request);
          check_field("fetch_address", exp_word.fetch_address, out_ch.fetch_address);
          check_field("irq_flag", exp_word.irq_flag, out_ch.irq_flag);
          check_field("playing", exp_word.playing, out_ch.playing);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        step_channel(in_ch.action, in_ch.fetched_byte, next_word);
        expected_words.push_back(next_word);
      end
    end

    mismatches   <= failures;
    pending      <= expected_words.size();
    fetch_wanted <= outstanding;
  end

endmodule

[tb/sv/tb_delta_sample_channel.sv]
// Testbench top for the delta sample channel: drives reset, register writes and
// input words, stalls the result side and reports the verdict. Depends on dsc_pkg,
// dsc_if, delta_sample_channel and dsc_result_checker.

module tb_delta_sample_channel;
  import dsc_pkg::*;

  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int         mismatches;
  int         pending;
  logic       fetch_wanted;
  int         words_sent = 0;
  int         idle_cycles = 0;
  int         sample_mode = 2;
  logic [1:0] last_action = ACT_TICK;

  dsc_in_if  in_ch ();
  dsc_out_if out_ch ();

  delta_sample_channel dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dsc_result_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .fetch_wanted (fetch_wanted)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic send_word(input logic [1:0] action, input logic [7:0] data);
    in_ch.valid        <= 1'b1;
    in_ch.action       <= action;
    in_ch.fetched_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    last_action = action;
    words_sent++;
  endtask

  function automatic logic [7:0] next_sample_byte();
    if ($urandom_range(0, 7) == 0) sample_mode = $urandom_range(0, 2);
    case (sample_mode)
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_word();
    logic want;
    int   pick;
    want = fetch_wanted && (last_action != ACT_DELIVER);
    pick = $urandom_range(0, 99);
    if (want) begin
      if (pick < 75) send_word(ACT_DELIVER, next_sample_byte());
      else send_word(ACT_TICK, 8'($urandom));
    end else if (pick < 3) begin
      send_word(ACT_START, 8'($urandom));
    end else if (pick < 5) begin
      send_word(ACT_DELIVER, 8'($urandom));
    end else if (pick < 7) begin
      send_word(ACT_UNUSED, 8'($urandom));
    end else begin
      send_word(ACT_TICK, 8'($urandom));
    end
  endtask

  task automatic wait_for_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [9:0] rate, input logic [15:0] start,
                           input logic [11:0] length, input logic loop_on,
                           input logic irq_on);
    wait_for_drain();
    write_register(REG_RATE_PERIOD, 32'(rate));
    write_register(REG_START_ADDRESS, 32'(start));
    write_register(REG_SAMPLE_LENGTH, 32'(length));
    write_register(REG_LOOP_ENABLE, 32'(loop_on));
    write_register(REG_IRQ_ENABLE, 32'(irq_on));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [9:0] rate, input logic [15:0] start,
                           input logic [11:0] length, input logic loop_on,
                           input logic irq_on, input int count);
    int burst_left;
    int gap;
    configure(rate, start, length, loop_on, irq_on);
    send_word(ACT_START, 8'($urandom));
    burst_left = $urandom_range(1, 40);
    for (int i = 1; i < count; i++) begin
      send_random_word();
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int mode;
    int span;
    bit held_off;
    held_off = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        @(posedge clk);
        if (!held_off && words_sent >= 700) begin
          held_off = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (60) @(posedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 9) < 7);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.fetched_byte <= 8'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // A zero period steps on every tick; the sample starts two bytes below the top
    // of memory so the address wraps, and the end of the sample raises the interrupt.
    configure(10'd0, 16'hFFFE, 12'd3, 1'b0, 1'b1);
    send_word(ACT_UNUSED, 8'hA5);
    send_word(ACT_DELIVER, 8'h5A);
    send_word(ACT_TICK, 8'h00);
    send_word(ACT_START, 8'h00);
    send_word(ACT_START, 8'h00);
    send_word(ACT_DELIVER, 8'hFF);
    repeat (8) send_word(ACT_TICK, 8'h00);
    send_word(ACT_DELIVER, 8'h00);
    send_word(ACT_DELIVER, 8'h80);
    repeat (8) send_word(ACT_TICK, 8'h00);
    send_word(ACT_DELIVER, 8'h01);
    send_word(ACT_START, 8'h00);
    in_ch.valid <= 1'b0;

    run_phase(10'd1, 16'h0000, 12'd2, 1'b1, 1'b0, 250);
    run_phase(10'd1023, 16'hFFFF, 12'd1, 1'b0, 1'b1, 60);
    run_phase(10'd0, 16'h1234, 12'd0, 1'b1, 1'b1, 150);
    for (int p = 0; p < 5; p++) begin
      run_phase(10'($urandom_range(1, 6)),
                $urandom_range(0, 1) ? 16'($urandom) : 16'hFFF8 + 16'($urandom_range(0, 7)),
                12'($urandom_range(1, 24)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 250);
    end
    run_phase(10'd2, 16'($urandom), 12'd4095, 1'b1, 1'b1, 200);

    wait_for_drain();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/dsc_pkg.sv
src/dsc_if.sv
src/delta_sample_channel.sv
tb/sv/dsc_result_checker.sv
tb/sv/tb_delta_sample_channel.sv
